>>> rtl/core/elv_pkg.sv
// ----------------------------------------------------------------------------
// elv_pkg
// Shared types, codes and scan helpers for the elevator car dispatcher.
// ----------------------------------------------------------------------------
package elv_pkg;

  localparam int FLOORS    = 16;
  localparam int FLOOR_W   = 4;
  localparam int ACT_W     = 3;
  localparam int CMD_W     = 3;
  localparam int CFG_DW    = 32;
  localparam int CFG_AW    = 3;
  localparam int EVQ_DEPTH = 4;
  localparam int EVQ_AW    = 2;

  localparam logic [15:0] DOOR_HOLD_RST = 16'd5000;
  localparam logic [15:0] UP_STOP_RST   = 16'd120;

  // event codes
  localparam logic [ACT_W-1:0] ACT_TICK       = 3'd0;
  localparam logic [ACT_W-1:0] ACT_REPORT     = 3'd1;
  localparam logic [ACT_W-1:0] ACT_DOOR_OPEN  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DOOR_CLOSE = 3'd3;
  localparam logic [ACT_W-1:0] ACT_CAB        = 3'd4;
  localparam logic [ACT_W-1:0] ACT_HALL_UP    = 3'd5;
  localparam logic [ACT_W-1:0] ACT_HALL_DN    = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE      = 3'd7;

  // car commands
  localparam logic [CMD_W-1:0] CMD_RESET = 3'd0;
  localparam logic [CMD_W-1:0] CMD_CLOSE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_UP    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DOWN  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_STOP  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_OPEN  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_LON   = 3'd6;
  localparam logic [CMD_W-1:0] CMD_LOFF  = 3'd7;

  // classified event, front to back
  typedef struct packed {
    logic               tick;
    logic               report;
    logic               door_open;
    logic               door_close;
    logic               cab;
    logic               hall_up;
    logic               hall_dn;
    logic [FLOOR_W-1:0] floor;
  } evt_t;

  typedef struct packed {
    logic [15:0] door_hold;
    logic [15:0] up_stop_delay;
  } cfg_t;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [FLOOR_W-1:0] light;
  } res_t;

  typedef struct packed {
    logic               found;
    logic [FLOOR_W-1:0] idx;
  } scan_t;

  // lowest set floor at or above c
  function automatic scan_t scan_up(logic [FLOORS-1:0] set, logic [FLOOR_W-1:0] c);
    scan_t r;
    r = '0;
    for (int i = FLOORS - 1; i >= 0; i--) begin
      if (set[i] && (i >= int'(c))) begin
        r.found = 1'b1;
        r.idx   = FLOOR_W'(i);
      end
    end
    return r;
  endfunction

  // highest set floor at or below c
  function automatic scan_t scan_down(logic [FLOORS-1:0] set, logic [FLOOR_W-1:0] c);
    scan_t r;
    r = '0;
    for (int i = 0; i < FLOORS; i++) begin
      if (set[i] && (i <= int'(c))) begin
        r.found = 1'b1;
        r.idx   = FLOOR_W'(i);
      end
    end
    return r;
  endfunction

endpackage

>>> rtl/core/elv_front.sv
// ----------------------------------------------------------------------------
// elv_front
// Accepts events, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module elv_front import elv_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [ACT_W-1:0]   in_action,
  input  logic [FLOOR_W-1:0] in_floor_number,
  output evt_t               evt,
  output logic               evt_valid,
  input  logic               evt_take
);

  evt_t              q_r [EVQ_DEPTH];
  logic [EVQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [EVQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [EVQ_AW:0]   cnt_r, cnt_nxt;
  logic              push_ok;
  logic              fl_ok;
  evt_t              cls;

  // floors past the top are dropped here
  assign fl_ok = ({1'b0, in_floor_number} < (FLOOR_W + 1)'(FLOORS));

  always_comb begin
    cls       = '0;
    cls.floor = in_floor_number;
    case (in_action)
      ACT_TICK, ACT_SPARE: cls.tick       = 1'b1;
      ACT_REPORT:          cls.report     = fl_ok;
      ACT_DOOR_OPEN:       cls.door_open  = 1'b1;
      ACT_DOOR_CLOSE:      cls.door_close = 1'b1;
      ACT_CAB:             cls.cab        = fl_ok;
      ACT_HALL_UP:         cls.hall_up    = fl_ok;
      ACT_HALL_DN:         cls.hall_dn    = fl_ok;
      default:             cls.tick       = 1'b1;
    endcase
  end

  assign full      = (cnt_r == (EVQ_AW + 1)'(EVQ_DEPTH));
  assign push_ok   = push & ~full;
  assign evt_valid = (cnt_r != '0);
  assign evt       = q_r[rd_ptr_r];

  assign wr_ptr_nxt = push_ok ? wr_ptr_r + 1'b1 : wr_ptr_r;
  assign rd_ptr_nxt = evt_take ? rd_ptr_r + 1'b1 : rd_ptr_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push_ok && !evt_take) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push_ok && evt_take) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

>>> rtl/core/elv_back.sv
// ----------------------------------------------------------------------------
// elv_back
// Car control state machine; turns one event into up to three commands.
// ----------------------------------------------------------------------------
module elv_back import elv_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  evt_t               evt,
  input  logic               evt_valid,
  output logic               evt_take,
  input  cfg_t               cfg,
  output logic               empty,
  input  logic               pop,
  output logic [CMD_W-1:0]   out_command,
  output logic [FLOOR_W-1:0] out_light_floor,
  output logic               out_last_of_run
);

  localparam logic [2:0] M_START    = 3'd0;
  localparam logic [2:0] M_IDLE     = 3'd1;
  localparam logic [2:0] M_CLOSE_UP = 3'd2;
  localparam logic [2:0] M_CLOSE_DN = 3'd3;
  localparam logic [2:0] M_UP       = 3'd4;
  localparam logic [2:0] M_ARRIVE   = 3'd5;
  localparam logic [2:0] M_DOWN     = 3'd6;
  localparam logic [2:0] M_WAIT     = 3'd7;

  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  typedef struct packed {
    res_t [2:0] e;
    logic [1:0] n;
  } rbuf_t;

  // append a command; extra ones past three are dropped
  function automatic rbuf_t emit(rbuf_t b, logic [CMD_W-1:0] c, logic [FLOOR_W-1:0] f);
    if (b.n != 2'd3) begin
      b.e[b.n].cmd   = c;
      b.e[b.n].light = f;
      b.n            = b.n + 2'd1;
    end
    return b;
  endfunction

  logic [2:0]         mode_r, mode_nxt;
  logic [FLOOR_W-1:0] cur_r, cur_nxt;
  logic [FLOOR_W-1:0] tgt_r, tgt_nxt;
  logic [1:0]         dir_r, dir_nxt;
  logic [FLOORS-1:0]  upr_r, upr_nxt;
  logic [FLOORS-1:0]  dnr_r, dnr_nxt;
  logic               closed_r, closed_nxt;
  logic [15:0]        delay_r, delay_nxt;
  res_t [3:0]         res_r;
  logic [1:0]         res_cnt_r, res_idx_r;

  rbuf_t              bb;
  scan_t              lo, hi, mv, ws;
  logic signed [5:0]  d_hi, d_lo;
  logic [15:0]        dec;
  logic               do_arrive, do_hold, do_depart, dep_up;
  logic               pop_ok, last;

  always_comb begin
    mode_nxt   = mode_r;
    cur_nxt    = cur_r;
    tgt_nxt    = tgt_r;
    dir_nxt    = dir_r;
    upr_nxt    = upr_r;
    dnr_nxt    = dnr_r;
    closed_nxt = closed_r;
    delay_nxt  = delay_r;
    bb         = '0;
    do_arrive  = 1'b0;
    do_hold    = 1'b0;
    do_depart  = 1'b0;
    dep_up     = 1'b0;
    mv         = '0;
    ws         = '0;

    // event side effects
    if (evt.report) begin
      cur_nxt = evt.floor;
    end
    if (evt.door_open) begin
      closed_nxt = 1'b0;
    end
    if (evt.door_close) begin
      closed_nxt = 1'b1;
    end
    if (evt.cab && (evt.floor != cur_r)) begin
      if (evt.floor > cur_r) begin
        upr_nxt[evt.floor] = 1'b1;
      end else begin
        dnr_nxt[evt.floor] = 1'b1;
      end
      bb = emit(bb, CMD_LON, evt.floor);
    end
    if (evt.hall_up) begin
      upr_nxt[evt.floor] = 1'b1;
    end
    if (evt.hall_dn) begin
      dnr_nxt[evt.floor] = 1'b1;
    end

    lo   = scan_up(upr_nxt, '0);
    hi   = scan_down(dnr_nxt, FLOOR_W'(FLOORS - 1));
    d_hi = $signed({2'b00, cur_nxt}) - $signed({2'b00, hi.idx});
    d_lo = $signed({2'b00, lo.idx}) - $signed({2'b00, cur_nxt});
    dec  = (delay_r != '0) ? delay_r - 16'd1 : delay_r;

    case (mode_r)
      M_START: begin
        bb       = emit(bb, CMD_RESET, '0);
        mode_nxt = M_IDLE;
      end
      M_IDLE: begin
        if (lo.found && hi.found) begin
          if (d_hi < d_lo) begin
            mv      = hi;
            dir_nxt = DIR_DOWN;
          end else begin
            mv      = lo;
            dir_nxt = DIR_UP;
          end
        end else if (hi.found) begin
          mv      = hi;
          dir_nxt = DIR_DOWN;
        end else if (lo.found) begin
          mv      = lo;
          dir_nxt = DIR_UP;
        end
        tgt_nxt = mv.found ? mv.idx : '0;
        if (mv.found) begin
          if (mv.idx > cur_nxt) begin
            do_depart = 1'b1;
            dep_up    = 1'b1;
          end else if (mv.idx < cur_nxt) begin
            do_depart = 1'b1;
          end else begin
            bb      = emit(bb, CMD_OPEN, '0);
            do_hold = 1'b1;
          end
        end
      end
      M_CLOSE_UP, M_CLOSE_DN: begin
        if (closed_nxt) begin
          bb       = emit(bb, (mode_r == M_CLOSE_UP) ? CMD_UP : CMD_DOWN, '0);
          mode_nxt = (mode_r == M_CLOSE_UP) ? M_UP : M_DOWN;
        end
      end
      M_UP, M_DOWN: begin
        case (dir_r)
          DIR_UP:   mv = (mode_r == M_UP) ? scan_up(upr_nxt, cur_nxt)
                                          : scan_down(upr_nxt, cur_nxt);
          DIR_DOWN: mv = (mode_r == M_UP) ? scan_up(dnr_nxt, cur_nxt)
                                          : scan_down(dnr_nxt, cur_nxt);
          default:  mv = '0;
        endcase
        tgt_nxt = mv.found ? mv.idx : '0;
        if (!mv.found) begin
          mode_nxt = M_IDLE;
        end else if (mv.idx == cur_nxt) begin
          if ((mode_r == M_DOWN) || (cfg.up_stop_delay == '0)) begin
            do_arrive = 1'b1;
          end else begin
            delay_nxt = cfg.up_stop_delay;
            mode_nxt  = M_ARRIVE;
          end
        end
      end
      M_ARRIVE: begin
        if (evt.tick) begin
          delay_nxt = dec;
          if (dec == '0) begin
            do_arrive = 1'b1;
          end
        end
      end
      M_WAIT: begin
        if (evt.tick) begin
          delay_nxt = dec;
          if (dec == '0) begin
            case (dir_r)
              DIR_UP:   ws = scan_up(upr_nxt, cur_nxt);
              DIR_DOWN: ws = scan_down(dnr_nxt, cur_nxt);
              default:  ws = '0;
            endcase
            tgt_nxt = ws.found ? ws.idx : '0;
            if (ws.found && (ws.idx > cur_nxt)) begin
              do_depart = 1'b1;
              dep_up    = 1'b1;
            end else if (ws.found && (ws.idx < cur_nxt)) begin
              do_depart = 1'b1;
            end else begin
              mode_nxt = M_IDLE;
            end
          end
        end
      end
      default: mode_nxt = M_IDLE;
    endcase

    if (do_arrive) begin
      bb      = emit(bb, CMD_STOP, '0);
      bb      = emit(bb, CMD_LOFF, tgt_nxt);
      bb      = emit(bb, CMD_OPEN, '0);
      do_hold = 1'b1;
    end
    if (do_hold) begin
      upr_nxt[tgt_nxt] = 1'b0;
      dnr_nxt[tgt_nxt] = 1'b0;
      delay_nxt        = cfg.door_hold;
      mode_nxt         = M_WAIT;
    end
    if (do_depart) begin
      bb = emit(bb, CMD_CLOSE, '0);
      if (closed_nxt) begin
        bb       = emit(bb, dep_up ? CMD_UP : CMD_DOWN, '0);
        mode_nxt = dep_up ? M_UP : M_DOWN;
      end else begin
        mode_nxt = dep_up ? M_CLOSE_UP : M_CLOSE_DN;
      end
    end
  end

  // result buffer: drained one per pop; next event enters on the last pop or when empty
  assign empty    = (res_idx_r == res_cnt_r);
  assign pop_ok   = pop & ~empty;
  assign last     = (({1'b0, res_idx_r} + 3'd1) == {1'b0, res_cnt_r});
  assign evt_take = evt_valid & (empty | (pop_ok & last));

  assign out_command     = res_r[res_idx_r].cmd;
  assign out_light_floor = res_r[res_idx_r].light;
  assign out_last_of_run = last;

  always_ff @(posedge clk) begin
    if (evt_take) begin
      res_r <= {res_t'('0), bb.e};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= M_START;
      cur_r     <= '0;
      tgt_r     <= '0;
      dir_r     <= DIR_NONE;
      upr_r     <= '0;
      dnr_r     <= '0;
      closed_r  <= 1'b1;
      delay_r   <= '0;
      res_cnt_r <= '0;
      res_idx_r <= '0;
    end else if (evt_take) begin
      mode_r    <= mode_nxt;
      cur_r     <= cur_nxt;
      tgt_r     <= tgt_nxt;
      dir_r     <= dir_nxt;
      upr_r     <= upr_nxt;
      dnr_r     <= dnr_nxt;
      closed_r  <= closed_nxt;
      delay_r   <= delay_nxt;
      res_cnt_r <= bb.n;
      res_idx_r <= '0;
    end else if (pop_ok) begin
      res_idx_r <= res_idx_r + 2'd1;
    end
  end

endmodule

>>> rtl/core/elevator_car_dispatcher_core.sv
// ----------------------------------------------------------------------------
// elevator_car_dispatcher_core
// Collective-control dispatcher for one elevator car, event in, commands out.
// ----------------------------------------------------------------------------
// Usage:
//   Events enter on push/full with in_action and in_floor_number; a
//   transaction completes on an edge with push high and full low. Commands
//   leave on empty/pop: the oldest command sits on out_command,
//   out_light_floor and out_last_of_run while empty is low, and a pop
//   transaction moves to the next one. out_last_of_run marks the final
//   command of an event; events that cause no command produce nothing.
//   With the command buffer free, the commands of an event are loaded at
//   the edge after its push transaction.
//   Throughput: the control state machine takes one event per cycle when it
//   yields at most one command and pop stays high; else the next event waits
//   for the last pop, a limit set by the single read port of the command
//   buffer, which holds up to three commands.
//   A four-entry event queue keeps push open while commands wait, so a
//   stalled receiver only backs up the queue; full rises when it fills.
//   Registers (APB, 32-bit): 0x0 door hold ticks, 0x4 up stop delay ticks.
//   Write them only while the block is quiet. pready is tied high.
//   Reset (rst_n low, synchronous) empties both queues, restores register
//   defaults and puts the car in start mode; the first event emits reset.
// ----------------------------------------------------------------------------
module elevator_car_dispatcher_core import elv_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // event channel
  input  logic               push,
  output logic               full,
  input  logic [ACT_W-1:0]   in_action,
  input  logic [FLOOR_W-1:0] in_floor_number,
  // command channel
  output logic               empty,
  input  logic               pop,
  output logic [CMD_W-1:0]   out_command,
  output logic [FLOOR_W-1:0] out_light_floor,
  output logic               out_last_of_run,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [CFG_AW-1:0]  paddr,
  input  logic [CFG_DW-1:0]  pwdata,
  output logic [CFG_DW-1:0]  prdata,
  output logic               pready
);

  localparam logic REG_DOOR_HOLD = 1'b0;
  localparam logic REG_UP_STOP   = 1'b1;

  cfg_t cfg_r, cfg_nxt;
  evt_t evt;
  logic evt_valid;
  logic evt_take;
  logic cfg_wr;
  logic reg_sel;

  // ---- register file ----
  // Register index is the word address; the low byte-address bits are ignored.
  assign pready  = 1'b1;
  assign reg_sel = paddr[CFG_AW-1];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (reg_sel)
        REG_DOOR_HOLD: cfg_nxt.door_hold     = pwdata[15:0];
        REG_UP_STOP:   cfg_nxt.up_stop_delay = pwdata[15:0];
        default:       cfg_nxt               = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_DOOR_HOLD: prdata = {16'd0, cfg_r.door_hold};
      REG_UP_STOP:   prdata = {16'd0, cfg_r.up_stop_delay};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.door_hold     <= DOOR_HOLD_RST;
      cfg_r.up_stop_delay <= UP_STOP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // ---- front: accept, classify, queue ----
  elv_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_action       (in_action),
    .in_floor_number (in_floor_number),
    .evt             (evt),
    .evt_valid       (evt_valid),
    .evt_take        (evt_take)
  );

  // ---- back: car control and command buffer ----
  elv_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .evt             (evt),
    .evt_valid       (evt_valid),
    .evt_take        (evt_take),
    .cfg             (cfg_r),
    .empty           (empty),
    .pop             (pop),
    .out_command     (out_command),
    .out_light_floor (out_light_floor),
    .out_last_of_run (out_last_of_run)
  );

  // ---- assertions ----
  // a command that is not the last of its event is always followed by more
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !empty && !out_last_of_run) |=> !empty)
    else $error("command run ended without last_of_run");

  // light floor is only carried by light commands
  a_light_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_command != CMD_LON) && (out_command != CMD_LOFF))
      |-> (out_light_floor == '0))
    else $error("light floor set on a non-light command");

  // door hold register write lands and reads back
  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr && (reg_sel == REG_DOOR_HOLD))
      |=> (prdata[15:0] == $past(pwdata[15:0])) || (reg_sel != REG_DOOR_HOLD))
    else $error("door hold register write lost");

  // an event leaves the queue only when the command buffer can take it
  a_take_gate: assert property (@(posedge clk) disable iff (!rst_n)
    (evt_take && !empty) |-> (pop && out_last_of_run))
    else $error("event taken over pending commands");

endmodule

>>> sim/tb_elevator_car_dispatcher_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_elevator_car_dispatcher_core
// Self-checking bench for the elevator car dispatcher: a directed walk through
// the car modes, then random traffic of calls, door events, ticks and floor
// sweeps under several register settings, checked command by command against
// an in-bench model of the car controller.
// ----------------------------------------------------------------------------
module tb_elevator_car_dispatcher_core;
  import elv_pkg::*;

  localparam int MAX_CMDS     = 3;   // commands one event can cause
  localparam int SETTLE_CYCLES = 12; // quiet time after the last command
  localparam int LONG_STALL   = 150; // receiver hold-off, in cycles
  localparam int STALL_AT     = 60;  // accepted events before the hold-off

  localparam logic [CFG_AW-1:0] ADDR_DOOR_HOLD = 3'h0;
  localparam logic [CFG_AW-1:0] ADDR_UP_STOP   = 3'h4;

  typedef enum logic [3:0] {
    MD_START, MD_IDLE, MD_CLOSE_UP, MD_CLOSE_DN,
    MD_UP, MD_ARRIVE_UP, MD_DOWN, MD_WAIT
  } car_mode_e;

  typedef enum logic [1:0] {DIR_NONE, DIR_UP, DIR_DN} car_dir_e;

  typedef struct packed {
    logic [ACT_W-1:0]   act;
    logic [FLOOR_W-1:0] fl;
  } car_event_t;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [FLOOR_W-1:0] light;
    logic               last;
  } car_cmd_t;

  // DUT ports, inputs all known from time zero
  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic [ACT_W-1:0]   in_action = '0;
  logic [FLOOR_W-1:0] in_floor_number = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic [CMD_W-1:0]   out_command;
  logic [FLOOR_W-1:0] out_light_floor;
  logic               out_last_of_run;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [CFG_AW-1:0]  paddr = '0;
  logic [CFG_DW-1:0]  pwdata = '0;
  logic [CFG_DW-1:0]  prdata;
  logic               pready;

  // stimulus bookkeeping
  car_event_t event_backlog[$];   // events not yet offered
  car_cmd_t   car_cmds_due[$];    // commands predicted, not yet popped
  car_cmd_t   run_cmds[$];        // commands of the event being modeled
  int         events_planned = 0;
  int         events_sent = 0;
  int         mismatches = 0;
  bit         in_fire = 1'b0;     // push transaction at the last rising edge
  bit         calm = 1'b0;        // no idling on either side
  int         gen_floor = 0;      // floor the traffic generator last reported
  bit         sweep_up = 1'b1;

  // model of the car controller
  car_mode_e          mode;
  car_dir_e           nxt_dir;
  logic [FLOOR_W-1:0] cur_fl, tgt_fl;
  bit                 tgt_ok;
  logic [FLOORS-1:0]  up_set, dn_set;
  bit                 door_shut;
  logic [15:0]        dly;
  logic [15:0]        hold_cfg, upstop_cfg;

  elevator_car_dispatcher_core DUT (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full), .in_action(in_action), .in_floor_number(in_floor_number),
    .empty(empty), .pop(pop), .out_command(out_command),
    .out_light_floor(out_light_floor), .out_last_of_run(out_last_of_run),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  // --------------------------------------------------------------------------
  // Car controller model
  // --------------------------------------------------------------------------
  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t: %s mismatch, got %0h want %0h", $time, what, got, want);
  endtask

  function automatic void reset_car_model();
    mode       = MD_START;
    nxt_dir    = DIR_NONE;
    cur_fl     = '0;
    tgt_fl     = '0;
    tgt_ok     = 1'b0;
    up_set     = '0;
    dn_set     = '0;
    door_shut  = 1'b1;
    dly        = '0;
    hold_cfg   = DOOR_HOLD_RST;
    upstop_cfg = UP_STOP_RST;
  endfunction

  function automatic int lowest_at_or_above(logic [FLOORS-1:0] set, int c);
    for (int f = c; f < FLOORS; f++)
      if (set[f]) return f;
    return -1;
  endfunction

  function automatic int highest_at_or_below(logic [FLOORS-1:0] set, int c);
    for (int f = c; f >= 0; f--)
      if (set[f]) return f;
    return -1;
  endfunction

  // excess commands beyond three are dropped, as the block does
  function automatic void emit_cmd(logic [CMD_W-1:0] c, logic [FLOOR_W-1:0] lf);
    car_cmd_t r;
    r.cmd   = c;
    r.light = lf;
    r.last  = 1'b0;
    if (run_cmds.size() < MAX_CMDS) run_cmds.push_back(r);
  endfunction

  function automatic void aim_at(int f);
    tgt_ok = (f >= 0);
    tgt_fl = (f >= 0) ? FLOOR_W'(f) : '0;
  endfunction

  function automatic void begin_hold();
    up_set[tgt_fl] = 1'b0;
    dn_set[tgt_fl] = 1'b0;
    dly  = hold_cfg;
    mode = MD_WAIT;
  endfunction

  function automatic void arrive();
    emit_cmd(CMD_STOP, '0);
    emit_cmd(CMD_LOFF, tgt_fl);
    emit_cmd(CMD_OPEN, '0);
    begin_hold();
  endfunction

  // close first; the move command waits for the door when it is still open
  function automatic void leave_floor(bit going_up);
    emit_cmd(CMD_CLOSE, '0);
    if (door_shut) begin
      emit_cmd(going_up ? CMD_UP : CMD_DOWN, '0);
      mode = going_up ? MD_UP : MD_DOWN;
    end else begin
      mode = going_up ? MD_CLOSE_UP : MD_CLOSE_DN;
    end
  endfunction

  // idle car: nearer of lowest up request and highest down request, ties go up
  function automatic void choose_idle_target();
    int lo, hi, c;
    lo = lowest_at_or_above(up_set, 0);
    hi = highest_at_or_below(dn_set, FLOORS - 1);
    c  = int'(cur_fl);
    if (lo >= 0 && hi >= 0) begin
      if ((c - hi) < (lo - c)) begin
        aim_at(hi);
        nxt_dir = DIR_DN;
      end else begin
        aim_at(lo);
        nxt_dir = DIR_UP;
      end
    end else if (hi >= 0) begin
      aim_at(hi);
      nxt_dir = DIR_DN;
    end else if (lo >= 0) begin
      aim_at(lo);
      nxt_dir = DIR_UP;
    end else begin
      aim_at(-1);
    end
  endfunction

  function automatic bit tick_down();
    if (dly > 0) dly--;
    return dly == 0;
  endfunction

  // Works out the commands one accepted event causes and queues them.
  // All 4-bit floors are below FLOORS, so no floor is out of range here.
  task automatic predict_commands(input logic [ACT_W-1:0] act,
                                  input logic [FLOOR_W-1:0] fl);
    bit                is_tick;
    bit                going_up;
    int                f;
    logic [FLOORS-1:0] scan_set;
    run_cmds.delete();
    is_tick = (act == ACT_TICK) || (act == ACT_SPARE);

    // event effects, whatever the mode
    case (act)
      ACT_REPORT:     cur_fl = fl;
      ACT_DOOR_OPEN:  door_shut = 1'b0;
      ACT_DOOR_CLOSE: door_shut = 1'b1;
      ACT_CAB: begin
        if (fl != cur_fl) begin
          if (fl > cur_fl) up_set[fl] = 1'b1;
          else dn_set[fl] = 1'b1;
          emit_cmd(CMD_LON, fl);
        end
      end
      ACT_HALL_UP: up_set[fl] = 1'b1;
      ACT_HALL_DN: dn_set[fl] = 1'b1;
      default: ;
    endcase

    case (mode)
      MD_START: begin
        emit_cmd(CMD_RESET, '0);
        mode = MD_IDLE;
      end
      MD_IDLE: begin
        choose_idle_target();
        if (tgt_ok) begin
          if (tgt_fl > cur_fl) leave_floor(1'b1);
          else if (tgt_fl < cur_fl) leave_floor(1'b0);
          else begin
            // request at the floor the car stands on
            emit_cmd(CMD_OPEN, '0);
            begin_hold();
          end
        end
      end
      MD_CLOSE_UP, MD_CLOSE_DN: begin
        if (door_shut) begin
          going_up = (mode == MD_CLOSE_UP);
          emit_cmd(going_up ? CMD_UP : CMD_DOWN, '0);
          mode = going_up ? MD_UP : MD_DOWN;
        end
      end
      MD_UP, MD_DOWN: begin
        // scan along travel, in the set that matches the next direction
        going_up = (mode == MD_UP);
        scan_set = (nxt_dir == DIR_UP) ? up_set : dn_set;
        if (nxt_dir == DIR_NONE) f = -1;
        else if (going_up) f = lowest_at_or_above(scan_set, int'(cur_fl));
        else f = highest_at_or_below(scan_set, int'(cur_fl));
        aim_at(f);
        if (!tgt_ok) begin
          mode = MD_IDLE;
        end else if (tgt_fl == cur_fl) begin
          if (!going_up || upstop_cfg == 0) begin
            arrive();
          end else begin
            dly  = upstop_cfg;
            mode = MD_ARRIVE_UP;
          end
        end
      end
      MD_ARRIVE_UP: begin
        if (is_tick) begin
          if (tick_down()) arrive();
        end
      end
      MD_WAIT: begin
        if (is_tick) begin
          if (tick_down()) begin
            if (nxt_dir == DIR_UP) f = lowest_at_or_above(up_set, int'(cur_fl));
            else if (nxt_dir == DIR_DN) f = highest_at_or_below(dn_set, int'(cur_fl));
            else f = -1;
            aim_at(f);
            if (tgt_ok && tgt_fl > cur_fl) leave_floor(1'b1);
            else if (tgt_ok && tgt_fl < cur_fl) leave_floor(1'b0);
            else mode = MD_IDLE;
          end
        end
      end
      default: mode = MD_IDLE;
    endcase

    if (run_cmds.size() > 0) run_cmds[run_cmds.size() - 1].last = 1'b1;
    foreach (run_cmds[i]) car_cmds_due.push_back(run_cmds[i]);
  endtask

  // --------------------------------------------------------------------------
  // Monitor: everything is sampled at the rising edge. Pops are checked before
  // the push of the same edge is modeled; a push cannot show up that early.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    car_cmd_t due;
    in_fire = rst_n && push && !full;
    if (!rst_n) begin
      reset_car_model();
      car_cmds_due.delete();
    end else begin
      if (pop && !empty) begin
        if (car_cmds_due.size() == 0) begin
          flag_mismatch("unexpected command", 32'(out_command), '0);
        end else begin
          due = car_cmds_due.pop_front();
          if (out_command !== due.cmd)
            flag_mismatch("command", 32'(out_command), 32'(due.cmd));
          if (out_light_floor !== due.light)
            flag_mismatch("light floor", 32'(out_light_floor), 32'(due.light));
          if (out_last_of_run !== due.last)
            flag_mismatch("last of run", 32'(out_last_of_run), 32'(due.last));
        end
      end
      if (in_fire) begin
        events_sent++;
        predict_commands(in_action, in_floor_number);
      end
      // register transactions keep the model's copy of the settings in step
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == ADDR_DOOR_HOLD) hold_cfg = pwdata[15:0];
          else if (paddr == ADDR_UP_STOP) upstop_cfg = pwdata[15:0];
        end else if (paddr == ADDR_DOOR_HOLD) begin
          if (prdata[15:0] !== hold_cfg)
            flag_mismatch("door hold readback", 32'(prdata[15:0]), 32'(hold_cfg));
        end else if (prdata[15:0] !== upstop_cfg) begin
          flag_mismatch("up stop readback", 32'(prdata[15:0]), 32'(upstop_cfg));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Event driver: offers the backlog at falling edges, holding an item until
  // its transaction goes through, with random idle gaps outside calm mode.
  // --------------------------------------------------------------------------
  int send_gap = 0;

  always @(negedge clk) begin
    car_event_t nxt;
    if (!rst_n) begin
      push <= 1'b0;
    end else if (push && !in_fire) begin
      // blocked by full: keep the same item on the ports
    end else if (send_gap > 0) begin
      push <= 1'b0;
      send_gap--;
    end else if (event_backlog.size() > 0) begin
      if (!calm && $urandom_range(0, 5) == 0) begin
        push <= 1'b0;
        send_gap = $urandom_range(0, 3);
      end else begin
        nxt = event_backlog.pop_front();
        in_action       <= nxt.act;
        in_floor_number <= nxt.fl;
        push            <= 1'b1;
      end
    end else begin
      push <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Command receiver: random stalls outside calm mode, plus one long hold-off
  // once traffic is under way so the event queue fills and full rises.
  // --------------------------------------------------------------------------
  int  pop_hold = 0;
  bit  long_stall_done = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (pop_hold > 0) begin
      pop <= 1'b0;
      pop_hold--;
    end else if (!long_stall_done && events_sent >= STALL_AT) begin
      long_stall_done = 1'b1;
      pop_hold = LONG_STALL - 1;
      pop <= 1'b0;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      pop <= 1'b0;
      pop_hold = $urandom_range(0, 3);
    end else begin
      pop <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic void queue_event(logic [ACT_W-1:0] act, logic [FLOOR_W-1:0] fl);
    car_event_t e;
    e.act = act;
    e.fl  = fl;
    event_backlog.push_back(e);
    events_planned++;
  endfunction

  // Random traffic. Floor reports walk the car one floor at a time so that
  // targets are actually reached; the rest is calls, door events and ticks,
  // with the odd jump in floor as noise.
  task automatic queue_traffic(input int n);
    int roll;
    repeat (n) begin
      roll = $urandom_range(0, 99);
      if (roll < 22) begin
        case ($urandom_range(0, 2))
          0: queue_event(ACT_CAB, FLOOR_W'($urandom_range(0, FLOORS - 1)));
          1: queue_event(ACT_HALL_UP, FLOOR_W'($urandom_range(0, FLOORS - 1)));
          default: queue_event(ACT_HALL_DN, FLOOR_W'($urandom_range(0, FLOORS - 1)));
        endcase
      end else if (roll < 32) begin
        queue_event(ACT_DOOR_CLOSE, FLOOR_W'($urandom));
      end else if (roll < 37) begin
        queue_event(ACT_DOOR_OPEN, FLOOR_W'($urandom));
      end else if (roll < 65) begin
        queue_event(($urandom_range(0, 9) == 0) ? ACT_SPARE : ACT_TICK,
                    FLOOR_W'($urandom));
      end else begin
        if (gen_floor == FLOORS - 1) sweep_up = 1'b0;
        else if (gen_floor == 0) sweep_up = 1'b1;
        else if ($urandom_range(0, 15) == 0) sweep_up = !sweep_up;
        gen_floor = sweep_up ? gen_floor + 1 : gen_floor - 1;
        if ($urandom_range(0, 19) == 0) gen_floor = $urandom_range(0, FLOORS - 1);
        queue_event(ACT_REPORT, FLOOR_W'(gen_floor));
      end
    end
  endtask

  // write one register, then read it back (checked by the monitor)
  task automatic program_reg(input logic [CFG_AW-1:0] addr, input logic [15:0] val);
    for (int rd = 0; rd < 2; rd++) begin
      @(negedge clk);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= (rd == 0);
      paddr   <= addr;
      pwdata  <= CFG_DW'(val);
      @(negedge clk);
      penable <= 1'b1;
      @(negedge clk);
      while (!pready) @(negedge clk);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
    end
  endtask

  // every event accepted and every command popped, then let the pipe go quiet
  task automatic settle();
    while (events_sent != events_planned || car_cmds_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic new_phase(input logic [15:0] hold, input logic [15:0] upstop);
    settle();
    program_reg(ADDR_DOOR_HOLD, hold);
    program_reg(ADDR_UP_STOP, upstop);
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // register defaults: first event gives reset, spare action acts as a tick
    queue_event(ACT_TICK, 4'd0);
    queue_event(ACT_SPARE, 4'd15);

    // directed walk with hold and stop delay at zero
    new_phase(16'd0, 16'd0);
    queue_event(ACT_CAB, 4'd3);         // light on, close, up
    queue_event(ACT_REPORT, 4'd1);
    queue_event(ACT_HALL_DN, 4'd2);
    queue_event(ACT_REPORT, 4'd3);      // up arrival with no delay
    queue_event(ACT_DOOR_OPEN, 4'd0);
    queue_event(ACT_TICK, 4'd0);        // zero hold ends at the first tick
    queue_event(ACT_DOOR_CLOSE, 4'd0);  // idle picks floor 2, goes down
    queue_event(ACT_REPORT, 4'd2);      // down arrival
    queue_event(ACT_TICK, 4'd0);
    queue_event(ACT_HALL_UP, 4'd2);     // request at the car's own floor
    queue_event(ACT_SPARE, 4'd9);
    queue_event(ACT_DOOR_OPEN, 4'd0);
    queue_event(ACT_HALL_UP, 4'd9);     // close only, door still open
    queue_event(ACT_TICK, 4'd0);
    queue_event(ACT_DOOR_CLOSE, 4'd0);  // move up now
    queue_event(ACT_CAB, 4'd15);
    queue_event(ACT_REPORT, 4'd9);
    queue_event(ACT_TICK, 4'd0);        // hold over, departs for 15
    queue_event(ACT_REPORT, 4'd15);
    queue_event(ACT_CAB, 4'd0);
    queue_event(ACT_TICK, 4'd0);
    queue_event(ACT_DOOR_CLOSE, 4'd0);  // idle picks floor 0
    queue_event(ACT_REPORT, 4'd0);
    queue_event(ACT_TICK, 4'd0);
    queue_event(ACT_CAB, 4'd0);         // cab button at own floor, ignored
    gen_floor = 0;

    new_phase(16'd3, 16'd2);
    queue_traffic(130);
    new_phase(16'($urandom_range(1, 6)), 16'($urandom_range(1, 5)));
    queue_traffic(120);

    // last part: both sides run flat out
    settle();
    calm = 1'b1;
    program_reg(ADDR_DOOR_HOLD, 16'($urandom_range(0, 4)));
    program_reg(ADDR_UP_STOP, 16'($urandom_range(0, 3)));
    queue_traffic(130);
    // largest delays last: a car that starts a hold here never leaves it
    new_phase(16'hFFFF, 16'hFFFF);
    queue_traffic(40);
    settle();

    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // safety net far beyond the slowest correct run
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

>>> files.f
rtl/core/elv_pkg.sv
rtl/core/elv_front.sv
rtl/core/elv_back.sv
rtl/core/elevator_car_dispatcher_core.sv
sim/tb_elevator_car_dispatcher_core.sv
